FILE: rtl/sspv_pkg.sv
// Shared types and codes for the sorted table block.
// No dependencies; imported by every file but the interfaces and the memory.
package sspv_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_LIST   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_DUP      = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4,
        ST_LISTED   = 3'd5,
        ST_EMPTY    = 3'd6
    } t_status;

    localparam logic [1:0] VIEW_ALL  = 2'd0;
    localparam logic [1:0] VIEW_EVEN = 2'd1;
    localparam logic [1:0] VIEW_ODD  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EX,
        S_TAIL,
        S_RESP,
        S_FLUSH
    } t_state;

    // Result of the shared compare unit for one table entry.
    typedef struct packed {
        logic eq;
        logic gt;
        logic view_hit;
    } t_cmp_res;

endpackage

FILE: rtl/sspv_if.sv
// Valid/ready channel interfaces for command words and result words.
// Depends on nothing; payload widths follow the block's fields.
interface sspv_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  cmd;
    logic signed [31:0] value;
    logic               descending;
    logic        [1:0]  view;

    modport source (output valid, cmd, value, descending, view, input ready);
    modport sink   (input valid, cmd, value, descending, view, output ready);
endinterface

interface sspv_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] item;
    logic        [2:0]  status;
    logic               below_one;
    logic               last;

    modport source (output valid, item, status, below_one, last, input ready);
    modport sink   (input valid, item, status, below_one, last, output ready);
endinterface

FILE: rtl/sspv_cmp.sv
// Shared compare unit: orders one table entry against the key and tests parity.
// Depends on sspv_pkg.
module sspv_cmp
    import sspv_pkg::*;
(
    input  logic signed [31:0] i_entry,
    input  logic signed [31:0] i_key,
    input  logic        [1:0]  i_view,
    output t_cmp_res           o_res
);

    always_comb begin
        o_res.eq = (i_entry == i_key);
        o_res.gt = (i_entry > i_key);
        case (i_view)
            VIEW_EVEN: o_res.view_hit = ~i_entry[0];
            VIEW_ODD:  o_res.view_hit = i_entry[0];
            default:   o_res.view_hit = 1'b1;
        endcase
    end

endmodule

FILE: rtl/sspv_mem.sv
// Table storage: one write port, one read port with registered read data.
// Does not import sspv_pkg; depth and address width come from its parameters.
module sspv_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic signed [31:0] i_wdata,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output logic signed [31:0] o_rdata
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sorted_set_parity_views.sv
// Sorted table of signed words with load, add, delete and list commands.
// Load/add/delete: one result word after a scan of up to N table entries,
// one scan step per read-then-compare pair through the single memory and compare unit.
// List: one word per hit, or one empty word if none; stalls on the result side hold the scan.
// Throughput: one command at a time; ready returns the cycle after its last word is loaded.
// Reset (synchronous, active low) empties the table; stored data is not cleared.
module sorted_set_parity_views
    import sspv_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sspv_in_if.sink   i_in,
    sspv_out_if.source o_out
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state              r_state, n_state;
    t_cmd                r_cmd;
    logic signed [31:0]  r_value;
    logic                r_desc;
    logic [1:0]          r_view;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_placed, n_placed;
    logic signed [31:0]  r_carry, n_carry;
    logic                r_pend_valid, n_pend_valid;
    logic signed [31:0]  r_pend, n_pend;
    t_status             r_res_status, n_res_status;

    logic                r_out_valid;
    logic signed [31:0]  r_out_item, n_out_item;
    t_status             r_out_status, n_out_status;
    logic                r_out_below, n_out_below;
    logic                r_out_last, n_out_last;
    logic                w_out_load;

    logic                w_in_acc;
    logic                w_full;
    logic                w_scan_end;
    logic                w_out_free;
    logic                w_list_hit_stall;
    logic [CNT_W-1:0]    w_list_addr;

    logic                w_we;
    logic [IDX_W-1:0]    w_waddr;
    logic signed [31:0]  w_wdata;
    logic                w_re;
    logic [IDX_W-1:0]    w_raddr;
    logic signed [31:0]  w_rdata;
    t_cmp_res            w_cmp;

    sspv_mem #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sspv_cmp u_cmp (
        .i_entry (w_rdata),
        .i_key   (r_value),
        .i_view  (r_view),
        .o_res   (w_cmp)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid & i_in.ready;
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_scan_end  = (r_idx == r_count);
    assign w_out_free  = ~r_out_valid | o_out.ready;
    // walk from the top only when listing in descending order
    assign w_list_addr = ((r_cmd == CMD_LIST) && r_desc) ? (r_count - CNT_W'(1) - r_idx)
                                                         : r_idx;
    assign w_list_hit_stall = (r_cmd == CMD_LIST) & w_cmp.view_hit & r_pend_valid
                              & ~w_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if ((t_cmd'(i_in.cmd) == CMD_LOAD) && w_full) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (w_scan_end) begin
                    case (r_cmd)
                        CMD_LOAD, CMD_ADD: n_state = w_full ? S_RESP : S_TAIL;
                        CMD_DELETE:        n_state = S_RESP;
                        default:           n_state = S_FLUSH;
                    endcase
                end else begin
                    n_state = S_EX;
                end
            end
            S_EX: begin
                if (w_list_hit_stall) begin
                    n_state = S_EX;
                end else if ((r_cmd == CMD_ADD) && !r_placed && w_cmp.eq) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_RD;
                end
            end
            S_TAIL: n_state = S_RESP;
            S_RESP, S_FLUSH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_idx        = r_idx;
        n_count      = r_count;
        n_placed     = r_placed;
        n_carry      = r_carry;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_res_status = r_res_status;
        n_out_item   = r_out_item;
        n_out_status = r_out_status;
        n_out_below  = r_out_below;
        n_out_last   = r_out_last;
        w_out_load   = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_idx[IDX_W-1:0];
        w_wdata      = r_carry;
        w_re         = 1'b0;
        w_raddr      = w_list_addr[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                n_idx        = '0;
                n_placed     = 1'b0;
                n_pend_valid = 1'b0;
                n_res_status = ST_FULL;
            end
            S_RD: begin
                if (w_scan_end) begin
                    case (r_cmd)
                        CMD_LOAD, CMD_ADD: n_res_status = ST_FULL;
                        CMD_DELETE: begin
                            if (r_placed) begin
                                n_count      = r_count - CNT_W'(1);
                                n_res_status = ST_REMOVED;
                            end else begin
                                n_res_status = ST_NOTFOUND;
                            end
                        end
                        default: n_res_status = ST_LISTED;
                    endcase
                end else begin
                    w_re = 1'b1;
                end
            end
            S_EX: begin
                case (r_cmd)
                    CMD_LOAD, CMD_ADD: begin
                        if (r_placed) begin
                            // ripple the displaced entry up by one slot
                            w_we    = 1'b1;
                            w_wdata = r_carry;
                            n_carry = w_rdata;
                        end else if ((r_cmd == CMD_ADD) && w_cmp.eq) begin
                            n_res_status = ST_DUP;
                        end else if (w_cmp.gt && !w_full) begin
                            w_we     = 1'b1;
                            w_wdata  = r_value;
                            n_carry  = w_rdata;
                            n_placed = 1'b1;
                        end
                        n_idx = r_idx + CNT_W'(1);
                    end
                    CMD_DELETE: begin
                        if (r_placed) begin
                            w_we    = 1'b1;
                            w_waddr = IDX_W'(r_idx - CNT_W'(1));
                            w_wdata = w_rdata;
                        end else if (w_cmp.eq) begin
                            n_placed = 1'b1;
                        end
                        n_idx = r_idx + CNT_W'(1);
                    end
                    default: begin
                        if (!w_list_hit_stall) begin
                            if (w_cmp.view_hit) begin
                                // hold the newest hit so the final one can carry last
                                if (r_pend_valid) begin
                                    w_out_load   = 1'b1;
                                    n_out_item   = r_pend;
                                    n_out_status = ST_LISTED;
                                    n_out_below  = 1'b0;
                                    n_out_last   = 1'b0;
                                end
                                n_pend       = w_rdata;
                                n_pend_valid = 1'b1;
                            end
                            n_idx = r_idx + CNT_W'(1);
                        end
                    end
                endcase
            end
            S_TAIL: begin
                w_we         = 1'b1;
                w_waddr      = r_count[IDX_W-1:0];
                w_wdata      = r_placed ? r_carry : r_value;
                n_count      = r_count + CNT_W'(1);
                n_res_status = ST_STORED;
            end
            S_RESP: begin
                if (w_out_free) begin
                    w_out_load   = 1'b1;
                    n_out_item   = r_value;
                    n_out_status = r_res_status;
                    n_out_below  = (r_cmd != CMD_DELETE) && (r_value < 32'sd1);
                    n_out_last   = 1'b1;
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    w_out_load   = 1'b1;
                    n_out_item   = r_pend_valid ? r_pend : 32'sd0;
                    n_out_status = r_pend_valid ? ST_LISTED : ST_EMPTY;
                    n_out_below  = 1'b0;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_idx        <= '0;
            r_placed     <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_placed     <= n_placed;
            r_pend_valid <= n_pend_valid;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd   <= t_cmd'(i_in.cmd);
            r_value <= i_in.value;
            r_desc  <= i_in.descending;
            r_view  <= i_in.view;
        end
        r_carry      <= n_carry;
        r_pend       <= n_pend;
        r_res_status <= n_res_status;
        if (w_out_load) begin
            r_out_item   <= n_out_item;
            r_out_status <= n_out_status;
            r_out_below  <= n_out_below;
            r_out_last   <= n_out_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.item      = r_out_item;
    assign o_out.status    = r_out_status;
    assign o_out.below_one = r_out_below;
    assign o_out.last      = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |->
            (r_count == $past(r_count) + CNT_W'(1)) ||
            (r_count == $past(r_count) - CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status != ST_LISTED)) |-> o_out.last)
        else $error("single result word without last");

    a_pend_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && (r_state != S_IDLE)) |-> (r_cmd == CMD_LIST))
        else $error("pending list word outside a list command");

endmodule

FILE: test/sorted_table_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted table block: watches the command and result channels,
// keeps its own sorted copy of the table and compares every result word in order.
// Depends on sspv_pkg and the channel interfaces sspv_in_if and sspv_out_if.
module sorted_table_checker
    import sspv_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sspv_in_if   i_cmd,
    sspv_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct {
        logic signed [31:0] item;
        t_status            status;
        logic               below_one;
        logic               last;
    } t_result_word;

    t_result_word       pending_results[$];
    logic signed [31:0] sorted_vals[CAPACITY];
    int                 fill = 0;
    int                 fail_count = 0;

    function automatic int find_value(logic signed [31:0] v);
        for (int i = 0; i < fill; i++) begin
            if (sorted_vals[i] == v) return i;
        end
        return -1;
    endfunction

    // Place after any equal values; caller has checked for room.
    task automatic insert_value(logic signed [31:0] v);
        int pos;
        pos = 0;
        while (pos < fill && sorted_vals[pos] <= v) pos++;
        for (int i = fill; i > pos; i--) sorted_vals[i] = sorted_vals[i - 1];
        sorted_vals[pos] = v;
        fill++;
    endtask

    task automatic push_result(logic signed [31:0] item, t_status status, logic below,
                               logic last);
        t_result_word w;
        w.item      = item;
        w.status    = status;
        w.below_one = below;
        w.last      = last;
        pending_results.push_back(w);
    endtask

    task automatic predict_results(t_cmd c, logic signed [31:0] v, logic desc,
                                   logic [1:0] view);
        logic               below;
        logic               hit;
        int                 pos;
        int                 idx;
        int                 hits;
        logic signed [31:0] e;
        below = (v < 32'sd1);
        case (c)
            CMD_LOAD: begin
                if (fill >= CAPACITY) begin
                    push_result(v, ST_FULL, below, 1'b1);
                end else begin
                    insert_value(v);
                    push_result(v, ST_STORED, below, 1'b1);
                end
            end
            CMD_ADD: begin
                if (find_value(v) >= 0) begin
                    push_result(v, ST_DUP, below, 1'b1);
                end else if (fill >= CAPACITY) begin
                    push_result(v, ST_FULL, below, 1'b1);
                end else begin
                    insert_value(v);
                    push_result(v, ST_STORED, below, 1'b1);
                end
            end
            CMD_DELETE: begin
                pos = find_value(v);
                if (pos < 0) begin
                    push_result(v, ST_NOTFOUND, 1'b0, 1'b1);
                end else begin
                    for (int i = pos; i + 1 < fill; i++) sorted_vals[i] = sorted_vals[i + 1];
                    fill--;
                    push_result(v, ST_REMOVED, 1'b0, 1'b1);
                end
            end
            default: begin
                hits = 0;
                for (int i = 0; i < fill; i++) begin
                    idx = desc ? (fill - 1 - i) : i;
                    e   = sorted_vals[idx];
                    // view 3 falls through to the full list
                    if (view == VIEW_EVEN)     hit = !e[0];
                    else if (view == VIEW_ODD) hit = e[0];
                    else                       hit = 1'b1;
                    if (hit) begin
                        push_result(e, ST_LISTED, 1'b0, 1'b0);
                        hits++;
                    end
                end
                if (hits == 0) push_result(32'sd0, ST_EMPTY, 1'b0, 1'b1);
                else pending_results[pending_results.size() - 1].last = 1'b1;
            end
        endcase
    endtask

    task automatic compare_word(t_result_word got);
        t_result_word want;
        if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%m: unexpected word item=%0d status=%0d below_one=%0b last=%0b",
                         got.item, got.status, got.below_one, got.last);
        end else begin
            want = pending_results.pop_front();
            if (got.item !== want.item || got.status !== want.status ||
                got.below_one !== want.below_one || got.last !== want.last) begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"%m: mismatch exp item=%0d status=%0d below_one=%0b last=%0b,",
                              " got item=%0d status=%0d below_one=%0b last=%0b"},
                             want.item, want.status, want.below_one, want.last,
                             got.item, got.status, got.below_one, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result_word got;
        if (!i_rst_n) begin
            pending_results.delete();
            fill = 0;
        end else begin
            // check the outgoing word before predicting from the incoming one
            if (i_res.valid && i_res.ready) begin
                got.item      = i_res.item;
                got.status    = t_status'(i_res.status);
                got.below_one = i_res.below_one;
                got.last      = i_res.last;
                compare_word(got);
            end
            if (i_cmd.valid && i_cmd.ready)
                predict_results(t_cmd'(i_cmd.cmd), i_cmd.value, i_cmd.descending,
                                i_cmd.view);
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_results.size();
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Top of the sorted table testbench: clock, reset, command stimulus and result
// back-pressure. Depends on sspv_pkg, the channel interfaces, the DUT and the checker.
module tb_top;
    import sspv_pkg::*;

    localparam int TABLE_DEPTH  = 32;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 10;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    int                 tx_idle_pct = 25;
    int                 rx_idle_pct = 65;
    logic               hold_rx = 1'b0;
    int                 fail_count;
    int                 pending;
    logic signed [31:0] value_pool[$];

    sspv_in_if  cmd_ch();
    sspv_out_if res_ch();

    sorted_set_parity_views #(.CAPACITY(TABLE_DEPTH)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_ch),
        .o_out  (res_ch)
    );

    sorted_table_checker #(.CAPACITY(TABLE_DEPTH)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_ch),
        .i_res       (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Result side: random stalls, plus the long hold-off when asked.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready = !hold_rx && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic signed [31:0] pick_value(logic from_pool);
        int k;
        k = $urandom_range(9);
        if (value_pool.size() > 0 && k < (from_pool ? 7 : 3))
            return value_pool[$urandom_range(value_pool.size() - 1)];
        if (k < 7) return int'($urandom_range(16)) - 8;
        return $urandom;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(t_cmd c, logic signed [31:0] v, logic desc, logic [1:0] view);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid      = 1'b1;
        cmd_ch.cmd        = c;
        cmd_ch.value      = v;
        cmd_ch.descending = desc;
        cmd_ch.view       = view;
        if (c == CMD_LOAD || c == CMD_ADD) begin
            value_pool.push_back(v);
            if (value_pool.size() > 48) void'(value_pool.pop_front());
        end
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_list(logic desc, logic [1:0] view);
        send_word(CMD_LIST, $urandom, desc, view);
    endtask

    task automatic run_random(int count, int list_pct);
        t_cmd c;
        repeat (count) begin
            if ($urandom_range(99) < list_pct) begin
                send_list(1'($urandom_range(1)), 2'($urandom_range(3)));
            end else begin
                c = t_cmd'($urandom_range(2));
                send_word(c, pick_value(c == CMD_DELETE), 1'($urandom_range(1)),
                          2'($urandom_range(3)));
            end
        end
    endtask

    // Load past capacity, hit the full cases, then delete most of it back out.
    task automatic fill_and_drain();
        logic signed [31:0] first_val;
        first_val = $urandom;
        send_word(CMD_LOAD, first_val, 1'b0, VIEW_ALL);
        repeat (TABLE_DEPTH + 7) send_word(CMD_LOAD, pick_value(1'b0), 1'b0, VIEW_ALL);
        send_word(CMD_ADD, first_val, 1'b0, VIEW_ALL);
        send_word(CMD_ADD, $urandom, 1'b1, VIEW_ODD);
        send_list(1'b1, VIEW_ALL);
        send_list(1'b0, VIEW_EVEN);
        repeat (20) send_word(CMD_DELETE, pick_value(1'b1), 1'($urandom_range(1)), VIEW_ALL);
    endtask

    task automatic hold_off(int cycles);
        @(posedge i_clk);
        hold_rx = 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_rx = 1'b0;
    endtask

    // Change idle rates away from the falling edge where the drivers read them.
    task automatic set_idle(int tx_pct, int rx_pct);
        cmd_ch.valid = 1'b0;
        @(posedge i_clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        @(negedge i_clk);
    endtask

    initial begin
        cmd_ch.valid      = 1'b0;
        cmd_ch.cmd        = CMD_LOAD;
        cmd_ch.value      = '0;
        cmd_ch.descending = 1'b0;
        cmd_ch.view       = VIEW_ALL;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table: empty view and a miss on delete
        send_list(1'b0, VIEW_ALL);
        send_word(CMD_DELETE, 32'sd7, 1'b0, VIEW_ALL);
        send_word(CMD_LOAD, 32'sh7FFFFFFF, 1'b0, VIEW_ALL);
        send_word(CMD_LOAD, 32'sh80000000, 1'b1, VIEW_EVEN);
        send_word(CMD_LOAD, 32'sd0, 1'b0, VIEW_ALL);
        send_word(CMD_LOAD, 32'sd1, 1'b0, VIEW_ALL);
        send_word(CMD_LOAD, -32'sd1, 1'b0, VIEW_ALL);
        send_word(CMD_LOAD, 32'sd5, 1'b0, VIEW_ALL);
        send_word(CMD_LOAD, 32'sd5, 1'b0, VIEW_ALL);
        send_word(CMD_ADD, 32'sd5, 1'b0, VIEW_ALL);
        send_word(CMD_ADD, 32'sd6, 1'b0, VIEW_ALL);
        send_word(CMD_ADD, -32'sd3, 1'b1, VIEW_ODD);
        send_list(1'b0, VIEW_ALL);
        send_list(1'b1, VIEW_ALL);
        send_list(1'b0, VIEW_EVEN);
        send_list(1'b1, VIEW_ODD);
        send_list(1'b0, 2'd3);
        send_word(CMD_DELETE, 32'sd5, 1'b0, VIEW_ALL);
        send_word(CMD_DELETE, 32'sd100, 1'b0, VIEW_ALL);
        send_word(CMD_ADD, 32'sh7FFFFFFF, 1'b0, VIEW_ALL);
        send_word(CMD_DELETE, 32'sh80000000, 1'b0, VIEW_ALL);
        send_list(1'b0, VIEW_ODD);
        send_word(CMD_DELETE, -32'sd1, 1'b0, VIEW_ALL);
        run_random(40, 20);

        set_idle(65, 25);
        fill_and_drain();

        set_idle(0, 0);
        fork
            hold_off(400);
            run_random(20, 50);
        join
        run_random(30, 20);

        cmd_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
